// File: design/cgr_pkg.sv
// ----------------------------------------------------------------------------
// cgr_pkg
// Shared types and constants of the text console glyph renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package cgr_pkg;

	localparam int GLYPH_HEIGHT  = 16;
	localparam int GLYPH_WIDTH   = 8;
	localparam int PAIRS_PER_ROW = GLYPH_WIDTH / 2;
	localparam int GLYPH_ENTRIES = 256 * GLYPH_HEIGHT;
	localparam int GADDR_W       = $clog2(GLYPH_ENTRIES);
	localparam int ROW_W         = $clog2(GLYPH_HEIGHT);
	localparam int PAIR_W        = $clog2(PAIRS_PER_ROW);
	localparam int CELL_W        = 14;
	localparam int CFG_IDX_W     = 3;

	localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
	localparam logic        OP_PUT       = 1'b0;
	localparam logic        OP_LOAD      = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLUMNS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_ROWS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INK_COLOR    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PAPER_COLOR  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FONT_READY   = 3'd6;

	localparam logic [31:0] RST_FRAME_BASE   = 32'hE000_0000;
	localparam logic [15:0] RST_LINE_PITCH   = 16'd4096;
	localparam logic [10:0] RST_TEXT_COLUMNS = 11'd128;
	localparam logic [4:0]  RST_GLYPH_ROWS   = 5'd16;
	localparam logic [31:0] RST_INK_COLOR    = 32'h00FF_FF00;
	localparam logic [31:0] RST_PAPER_COLOR  = 32'h0000_2366;

	typedef struct packed {
		logic       op;
		logic [7:0] char_code;
		logic [3:0] glyph_line;
		logic [7:0] glyph_bits;
	} in_item_t;

	typedef struct packed {
		logic [31:0]       pixel_address;
		logic [31:0]       left_color;
		logic [31:0]       right_color;
		logic              cell_write;
		logic [CELL_W-1:0] cell_index;
		logic [7:0]        cell_char;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic load_glyph;
		logic newline;
		logic capture;
		logic mul;
		logic sum;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic op_load;
		logic is_newline;
		logic font_ready;
		logic out_free;
		logic pair_last;
		logic row_last;
	} sts_t;

endpackage

`default_nettype wire

// File: design/cgr_ctrl.sv
// ----------------------------------------------------------------------------
// cgr_ctrl
// Controller state machine: accepts items and sequences the draw of a glyph.
// ----------------------------------------------------------------------------
`default_nettype none

module cgr_ctrl
	import cgr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MUL  = 2'd1;
	localparam logic [1:0] S_SUM  = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       in_fire;

	assign in_stall = (state_q != S_IDLE);
	assign in_fire  = in_valid && (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (sts.op_load) begin
						cmd.load_glyph = 1'b1;
					end else if (sts.font_ready) begin
						if (sts.is_newline) begin
							cmd.newline = 1'b1;
						end else begin
							cmd.capture = 1'b1;
							state_d     = S_MUL;
						end
					end
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.pair_last && sts.row_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: design/cgr_datapath.sv
// ----------------------------------------------------------------------------
// cgr_datapath
// Configuration registers, glyph store, cursor, address arithmetic and the
// output register of the glyph renderer.
// ----------------------------------------------------------------------------
`default_nettype none

module cgr_datapath
	import cgr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data,
	input  wire in_item_t             in_data,
	input  wire logic                 out_stall,
	output logic                      out_valid,
	output out_item_t                 out_data,
	input  wire cmd_t                 cmd,
	output sts_t                      sts
);

	logic [31:0] frame_base_q;
	logic [15:0] line_pitch_q;
	logic [10:0] text_columns_q;
	logic [4:0]  glyph_rows_q;
	logic [31:0] ink_color_q;
	logic [31:0] paper_color_q;
	logic        font_ready_q;

	logic [15:0] cur_col_q;
	logic [15:0] cur_row_q;

	logic [7:0]        glyph_mem [GLYPH_ENTRIES];
	logic [7:0]        glyph_q;
	logic [ROW_W-1:0]  rd_row;

	logic [7:0]        code_q;
	logic [ROW_W-1:0]  row_q;
	logic [PAIR_W-1:0] pair_q;
	logic              first_q;
	logic [31:0]       prod_q;
	logic [CELL_W-1:0] cell_mul_q;
	logic [CELL_W-1:0] cell_q;
	logic [31:0]       line_addr_q;

	logic              out_valid_q;
	out_item_t         out_q;

	logic [4:0]        rows_eff;
	logic [35:0]       addr_prod;
	logic [24:0]       cell_prod;
	logic [15:0]       col_inc;
	logic              final_emit;
	logic [2:0]        left_bit;
	logic [2:0]        right_bit;
	logic              cols_nz;

	assign cols_nz = (text_columns_q != 11'd0);

	always_comb begin
		if (glyph_rows_q == 5'd0) begin
			rows_eff = 5'd1;
		end else if (glyph_rows_q > 5'(GLYPH_HEIGHT)) begin
			rows_eff = 5'(GLYPH_HEIGHT);
		end else begin
			rows_eff = glyph_rows_q;
		end
	end

	assign sts.op_load    = (in_data.op == OP_LOAD);
	assign sts.is_newline = (in_data.char_code == NEWLINE_CODE);
	assign sts.font_ready = font_ready_q;
	assign sts.out_free   = !out_valid_q || !out_stall;
	assign sts.pair_last  = (pair_q == PAIR_W'(PAIRS_PER_ROW - 1));
	assign sts.row_last   = ({1'b0, row_q} == (rows_eff - 5'd1));

	assign final_emit = cmd.emit && sts.pair_last && sts.row_last;
	assign addr_prod  = {cur_row_q, 4'b0000} * line_pitch_q;
	assign cell_prod  = cur_row_q[CELL_W-1:0] * text_columns_q;
	assign col_inc    = cur_col_q + 16'd1;
	assign rd_row     = (cmd.emit && sts.pair_last) ? row_q + ROW_W'(1) : row_q;
	assign left_bit   = {~pair_q, 1'b1};
	assign right_bit  = {~pair_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q   <= RST_FRAME_BASE;
			line_pitch_q   <= RST_LINE_PITCH;
			text_columns_q <= RST_TEXT_COLUMNS;
			glyph_rows_q   <= RST_GLYPH_ROWS;
			ink_color_q    <= RST_INK_COLOR;
			paper_color_q  <= RST_PAPER_COLOR;
			font_ready_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_BASE:   frame_base_q   <= cfg_data;
				CFG_LINE_PITCH:   line_pitch_q   <= cfg_data[15:0];
				CFG_TEXT_COLUMNS: text_columns_q <= cfg_data[10:0];
				CFG_GLYPH_ROWS:   glyph_rows_q   <= cfg_data[4:0];
				CFG_INK_COLOR:    ink_color_q    <= cfg_data;
				CFG_PAPER_COLOR:  paper_color_q  <= cfg_data;
				CFG_FONT_READY:   font_ready_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_glyph) begin
			glyph_mem[{in_data.char_code, in_data.glyph_line}] <= in_data.glyph_bits;
		end
		glyph_q <= glyph_mem[{code_q, rd_row}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
		end else if (cmd.newline) begin
			cur_col_q <= '0;
			cur_row_q <= cur_row_q + 16'd1;
		end else if (final_emit) begin
			if (cols_nz && (col_inc >= {5'b0, text_columns_q})) begin
				cur_col_q <= '0;
				cur_row_q <= cur_row_q + 16'd1;
			end else begin
				cur_col_q <= col_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			pair_q  <= '0;
			first_q <= 1'b0;
		end else if (cmd.capture) begin
			row_q   <= '0;
			pair_q  <= '0;
			first_q <= 1'b1;
		end else if (cmd.emit) begin
			pair_q  <= pair_q + PAIR_W'(1);
			first_q <= 1'b0;
			if (sts.pair_last) begin
				row_q <= row_q + ROW_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			code_q <= in_data.char_code;
		end
		if (cmd.mul) begin
			prod_q     <= addr_prod[31:0];
			cell_mul_q <= cell_prod[CELL_W-1:0];
		end
		if (cmd.sum) begin
			line_addr_q <= frame_base_q + prod_q + {11'b0, cur_col_q, 5'b00000};
			cell_q      <= cell_mul_q + cur_col_q[CELL_W-1:0];
		end else if (cmd.emit && sts.pair_last) begin
			line_addr_q <= line_addr_q + {16'b0, line_pitch_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.pixel_address <= line_addr_q + {27'b0, pair_q, 3'b000};
			out_q.left_color    <= glyph_q[left_bit] ? ink_color_q : paper_color_q;
			out_q.right_color   <= glyph_q[right_bit] ? ink_color_q : paper_color_q;
			out_q.cell_write    <= first_q && cols_nz;
			out_q.cell_index    <= (first_q && cols_nz) ? cell_q : '0;
			out_q.cell_char     <= (first_q && cols_nz) ? code_q : 8'd0;
			out_q.last          <= sts.pair_last && sts.row_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// File: design/console_glyph_renderer.sv
// Flow: a drawn character is captured, then passes the multiply, sum and emit states.
// A drawn character gives 4 pairs per glyph row, one per cycle while the output is not
// stalled, and no new item is accepted until its last pair is emitted; load, newline and
// ignored items leave the controller idle. Output stalls lengthen a draw.
// Reset clears the cursor, the control state and sets the registers to their defaults;
// the glyph store holds no defined content until it is loaded.
// ----------------------------------------------------------------------------
// console_glyph_renderer
// Text console renderer: loads glyph rows and draws characters as pixel pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module console_glyph_renderer
	import cgr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_item_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_item_t                 out_data
);

	cmd_t cmd;
	sts_t sts;

	cgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	cgr_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

// File: sim/tb_console_glyph_renderer.sv
// ----------------------------------------------------------------------------
// tb_console_glyph_renderer
// Self-checking testbench of the text console glyph renderer. Load and put
// items are fed through the input channel in random bursts, and every pixel
// pair is checked against an in-bench prediction of the glyph store, the
// cursor and the registers. The run covers the register extremes, address
// wrap at 32 bits, a shrinking column count and several random register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_console_glyph_renderer
	import cgr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD     = 2;
	localparam int RESET_CYCLES    = 11;
	localparam int SETTLE_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int RANDOM_PHASES   = 6;
	localparam int ITEMS_PER_PHASE = 20;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_stall;
	out_item_t            out_data;

	// Register copies used for prediction.
	logic [31:0] m_frame_base;
	logic [15:0] m_line_pitch;
	logic [10:0] m_text_columns;
	logic [4:0]  m_glyph_rows;
	logic [31:0] m_ink;
	logic [31:0] m_paper;
	logic        m_font_ready;

	logic [7:0]  font_mirror [GLYPH_ENTRIES];
	logic [15:0] cur_col;
	logic [15:0] cur_row;
	out_item_t   due_pairs [$];

	// Generator bookkeeping: which glyph rows have been loaded so far.
	logic        font_defined [GLYPH_ENTRIES];
	logic [7:0]  known_codes [$];
	in_item_t    feed [$];
	int          items_sent;
	int          items_taken;

	logic in_fire;
	int   burst_left;
	int   gap_left;
	int   stall_mode;
	int   stall_mode_left;
	int   stall_run;
	int   stall_tick;
	int   quiet_cycles;

	int errors;
	int pairs_checked;
	int n_loads;
	int n_drawn;
	int n_newlines;
	int n_ignored;
	int n_phases;

	console_glyph_renderer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic int drawn_rows(input logic [4:0] setting);
		if (setting == 0) return 1;
		if (setting > GLYPH_HEIGHT) return GLYPH_HEIGHT;
		return int'(setting);
	endfunction

	task automatic render_item(input in_item_t it);
		out_item_t  pair;
		int         rows;
		int         r;
		int         p;
		logic [7:0] bits;
		logic [31:0] y;
		logic [31:0] px;
		logic [31:0] cell_pos;
		if (it.op == OP_LOAD) begin
			font_mirror[it.char_code * GLYPH_HEIGHT + it.glyph_line] = it.glyph_bits;
			n_loads++;
		end else if (!m_font_ready) begin
			n_ignored++;
		end else if (it.char_code == NEWLINE_CODE) begin
			cur_col = '0;
			cur_row = cur_row + 16'd1;
			n_newlines++;
		end else begin
			rows = drawn_rows(m_glyph_rows);
			for (r = 0; r < rows; r++) begin
				bits = font_mirror[it.char_code * GLYPH_HEIGHT + r];
				y = {16'd0, cur_row} * GLYPH_HEIGHT + r;
				for (p = 0; p < PAIRS_PER_ROW; p++) begin
					px = {16'd0, cur_col} * GLYPH_WIDTH + 2 * p;
					pair = '0;
					pair.pixel_address = m_frame_base + y * m_line_pitch + px * 4;
					pair.left_color = bits[7 - 2 * p] ? m_ink : m_paper;
					pair.right_color = bits[6 - 2 * p] ? m_ink : m_paper;
					pair.last = (r == rows - 1) && (p == PAIRS_PER_ROW - 1);
					if (r == 0 && p == 0 && m_text_columns != 0) begin
						cell_pos = cur_row * m_text_columns + cur_col;
						pair.cell_write = 1'b1;
						pair.cell_index = cell_pos[CELL_W-1:0];
						pair.cell_char = it.char_code;
					end
					due_pairs.push_back(pair);
				end
			end
			cur_col = cur_col + 16'd1;
			if (m_text_columns != 0 && cur_col >= m_text_columns) begin
				cur_col = '0;
				cur_row = cur_row + 16'd1;
			end
			n_drawn++;
		end
	endtask

	task automatic note_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CFG_FRAME_BASE:   m_frame_base = value;
			CFG_LINE_PITCH:   m_line_pitch = value[15:0];
			CFG_TEXT_COLUMNS: m_text_columns = value[10:0];
			CFG_GLYPH_ROWS:   m_glyph_rows = value[4:0];
			CFG_INK_COLOR:    m_ink = value;
			CFG_PAPER_COLOR:  m_paper = value;
			CFG_FONT_READY:   m_font_ready = value[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_item(input logic op, input logic [7:0] code,
			input logic [3:0] line, input logic [7:0] bits);
		in_item_t it;
		it.op = op;
		it.char_code = code;
		it.glyph_line = line;
		it.glyph_bits = bits;
		feed.push_back(it);
		items_sent++;
		if (op == OP_LOAD) begin
			font_defined[code * GLYPH_HEIGHT + line] = 1'b1;
		end
	endtask

	task automatic queue_put(input logic [7:0] code);
		queue_item(OP_PUT, code, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
	endtask

	task automatic define_glyph(input logic [7:0] code);
		int r;
		for (r = 0; r < drawn_rows(m_glyph_rows); r++) begin
			if (!font_defined[code * GLYPH_HEIGHT + r])
				queue_item(OP_LOAD, code, 4'(r), 8'($urandom_range(0, 255)));
		end
		known_codes.push_back(code);
	endtask

	task automatic fill_random(input int count);
		int         start;
		int         choice;
		int         reps;
		logic [7:0] code;
		start = items_sent;
		while (items_sent - start < count) begin
			choice = $urandom_range(0, 99);
			code = 8'($urandom_range(0, 255));
			if (choice < 15) begin
				queue_item(OP_LOAD, code, 4'($urandom_range(0, 15)),
					8'($urandom_range(0, 255)));
			end else if (choice < 25) begin
				queue_put(NEWLINE_CODE);
			end else if (!m_font_ready) begin
				queue_put(code);
			end else begin
				if (choice < 60 && known_codes.size() != 0)
					code = known_codes[$urandom_range(0, known_codes.size() - 1)];
				if (code == NEWLINE_CODE)
					code = code ^ 8'h01;
				define_glyph(code);
				reps = $urandom_range(1, 3);
				repeat (reps) queue_put(code);
			end
		end
	endtask

	task automatic drain();
		do @(negedge clk);
		while (items_taken != items_sent || due_pairs.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		n_phases++;
	endtask

	// Input driver: bursts of items with random gaps between them.
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (feed.size() != 0) begin
				in_data <= feed.pop_front();
				in_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
						: $urandom_range(1, 6);
					gap_left = $urandom_range(1, 8);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output stall pattern: switches between free running, random, periodic and long stalls.
	always @(negedge clk) begin
		stall_tick++;
		if (stall_mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_mode_left = $urandom_range(20, 300);
		end else begin
			stall_mode_left--;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 2) == 0);
			2: out_stall <= (stall_tick % 4 == 3);
			default: begin
				if (stall_run > 0) begin
					stall_run--;
					out_stall <= 1'b1;
				end else begin
					out_stall <= 1'b0;
					if ($urandom_range(0, 5) == 0)
						stall_run = $urandom_range(1, 12);
				end
			end
		endcase
	end

	always @(posedge clk) begin
		in_fire <= in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			render_item(in_data);
			items_taken++;
		end
	end

	always @(posedge clk) begin : check_pairs
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_pairs.size() == 0) begin
				$display("%0t: pixel pair with none expected, actual %p", $time, out_data);
				errors++;
			end else begin
				want = due_pairs.pop_front();
				note_field("pixel_address", want.pixel_address, out_data.pixel_address);
				note_field("left_color", want.left_color, out_data.left_color);
				note_field("right_color", want.right_color, out_data.right_color);
				note_field("cell_write", 32'(want.cell_write), 32'(out_data.cell_write));
				note_field("cell_index", 32'(want.cell_index), 32'(out_data.cell_index));
				note_field("cell_char", 32'(want.cell_char), 32'(out_data.cell_char));
				note_field("last", 32'(want.last), 32'(out_data.last));
				pairs_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int ph;
		int r;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		in_fire = 1'b0;
		burst_left = 1;
		gap_left = 0;
		stall_mode = 0;
		stall_mode_left = 0;
		stall_run = 0;
		stall_tick = 0;
		quiet_cycles = 0;
		items_sent = 0;
		items_taken = 0;
		errors = 0;
		pairs_checked = 0;
		n_loads = 0;
		n_drawn = 0;
		n_newlines = 0;
		n_ignored = 0;
		n_phases = 0;
		for (r = 0; r < GLYPH_ENTRIES; r++) begin
			font_mirror[r] = '0;
			font_defined[r] = 1'b0;
		end
		cur_col = '0;
		cur_row = '0;
		m_frame_base = RST_FRAME_BASE;
		m_line_pitch = RST_LINE_PITCH;
		m_text_columns = RST_TEXT_COLUMNS;
		m_glyph_rows = RST_GLYPH_ROWS;
		m_ink = RST_INK_COLOR;
		m_paper = RST_PAPER_COLOR;
		m_font_ready = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Font not ready yet: puts are dropped while loads still land.
		queue_put(8'h41);
		queue_put(NEWLINE_CODE);
		for (r = 0; r < GLYPH_HEIGHT; r++) begin
			case (r)
				0: queue_item(OP_LOAD, 8'hFF, 4'(r), 8'hFF);
				1: queue_item(OP_LOAD, 8'hFF, 4'(r), 8'h00);
				2: queue_item(OP_LOAD, 8'hFF, 4'(r), 8'h80);
				3: queue_item(OP_LOAD, 8'hFF, 4'(r), 8'h01);
				default: queue_item(OP_LOAD, 8'hFF, 4'(r), 8'($urandom_range(0, 255)));
			endcase
		end
		queue_item(OP_LOAD, 8'h00, 4'd0, 8'h5A);
		drain();

		// Register extremes: wrapping addresses, no columns, zero glyph rows.
		set_reg(CFG_FRAME_BASE, 32'hFFFF_FFF0);
		set_reg(CFG_LINE_PITCH, 32'h0000_FFFF);
		set_reg(CFG_TEXT_COLUMNS, 32'd0);
		set_reg(CFG_GLYPH_ROWS, 32'd0);
		set_reg(CFG_INK_COLOR, 32'hFFFF_FFFF);
		set_reg(CFG_PAPER_COLOR, 32'h0000_0000);
		set_reg(CFG_FONT_READY, 32'd1);
		queue_put(8'h00);
		queue_put(8'hFF);
		queue_put(8'h00);
		queue_put(NEWLINE_CODE);
		queue_put(8'hFF);
		drain();

		// The column count is set to no more than the cursor column, and glyph rows saturate.
		set_reg(CFG_FRAME_BASE, 32'd0);
		set_reg(CFG_LINE_PITCH, 32'd0);
		set_reg(CFG_TEXT_COLUMNS, 32'd1);
		set_reg(CFG_GLYPH_ROWS, 32'd31);
		queue_put(8'hFF);
		queue_put(8'hFF);
		queue_put(NEWLINE_CODE);
		drain();

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			set_reg(CFG_FRAME_BASE, $urandom);
			case ($urandom_range(0, 3))
				0: set_reg(CFG_LINE_PITCH, 32'd0);
				1: set_reg(CFG_LINE_PITCH, 32'h0000_FFFF);
				default: set_reg(CFG_LINE_PITCH, $urandom_range(0, 65535));
			endcase
			case ($urandom_range(0, 5))
				0: set_reg(CFG_TEXT_COLUMNS, 32'd0);
				1: set_reg(CFG_TEXT_COLUMNS, 32'd1);
				2: set_reg(CFG_TEXT_COLUMNS, 32'd3);
				3: set_reg(CFG_TEXT_COLUMNS, 32'd80);
				4: set_reg(CFG_TEXT_COLUMNS, 32'd1024);
				default: set_reg(CFG_TEXT_COLUMNS, $urandom_range(0, 1024));
			endcase
			if (ph == RANDOM_PHASES - 1)
				set_reg(CFG_GLYPH_ROWS, GLYPH_HEIGHT);
			else if ($urandom_range(0, 9) < 7)
				set_reg(CFG_GLYPH_ROWS, $urandom_range(1, 4));
			else
				set_reg(CFG_GLYPH_ROWS, $urandom_range(0, 31));
			set_reg(CFG_INK_COLOR, $urandom);
			set_reg(CFG_PAPER_COLOR, $urandom);
			set_reg(CFG_FONT_READY, (ph == 2) ? 32'd0 : 32'd1);
			fill_random(ITEMS_PER_PHASE);
			drain();
		end

		$display("Covered %0d phases: %0d glyph rows loaded, %0d characters drawn,",
			n_phases, n_loads, n_drawn);
		$display("%0d newlines, %0d puts dropped, %0d pixel pairs checked, %0d mismatches.",
			n_newlines, n_ignored, pairs_checked, errors);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
design/cgr_pkg.sv
design/cgr_ctrl.sv
design/cgr_datapath.sv
design/console_glyph_renderer.sv
sim/tb_console_glyph_renderer.sv
